FILE: sv/rgb_to_hsv_converter_assert.svh
// ----------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// immediate-style wrappers for concurrent checks, compiled out under SYNTH
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter: implication check failed");

// next-cycle implication
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter: next-cycle check failed");

`else

`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the rgb to hsv converter pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_BITS      = 15;

  localparam int CH_MAX     = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_UNIT   = 60 * (1 << HUE_FRAC_BITS);
  localparam int HUE_CIRCLE = 6 * HUE_UNIT;

  // hue quotient is at most HUE_UNIT, saturation quotient at most CH_MAX
  localparam int HUE_QUO_BITS = $clog2(HUE_UNIT + 1);
  localparam int QUO_BITS     = (HUE_QUO_BITS > CHANNEL_BITS) ? HUE_QUO_BITS : CHANNEL_BITS;
  localparam int REM_BITS     = QUO_BITS + CHANNEL_BITS;
  localparam int HUE_CALC_BITS = $clog2(HUE_CIRCLE) + 2;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] value;
  } hsv_t;

  // one word of the shared divider pipeline
  typedef struct packed {
    logic [REM_BITS-1:0]     hue_rem;
    logic [REM_BITS-1:0]     sat_rem;
    logic [QUO_BITS-1:0]     hue_quo;
    logic [QUO_BITS-1:0]     sat_quo;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] max_val;
    logic                    neg;
    logic                    grey;
    sector_e                 sector;
  } div_data_t;

endpackage

`default_nettype wire

FILE: sv/rhc_div_stage.sv
// ----------------------------------------------------------------------------
// rhc_div_stage
// one restoring division step for hue and saturation, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_stage #(
  parameter int STEP_BIT = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rhc_pkg::div_data_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rhc_pkg::div_data_t      out_data_o
);

  logic                           valid_q;
  rhc_pkg::div_data_t             data_d, data_q;
  logic [rhc_pkg::REM_BITS-1:0]   hue_shift, sat_shift;

  always_comb begin
    hue_shift = rhc_pkg::REM_BITS'(in_data_i.delta) << STEP_BIT;
    sat_shift = rhc_pkg::REM_BITS'(in_data_i.max_val) << STEP_BIT;
    data_d = in_data_i;
    if (in_data_i.hue_rem >= hue_shift) begin
      data_d.hue_rem           = in_data_i.hue_rem - hue_shift;
      data_d.hue_quo[STEP_BIT] = 1'b1;
    end
    if (in_data_i.sat_rem >= sat_shift) begin
      data_d.sat_rem           = in_data_i.sat_rem - sat_shift;
      data_d.sat_quo[STEP_BIT] = 1'b1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: sv/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pipelined rgb to hsv pixel conversion with a bit-per-stage divider
// ----------------------------------------------------------------------------
// a pixel passes the stage 1, stage 2, divider and output registers in order
// throughput: one pixel per cycle unless the output stalls, set by the fully
//   pipelined restoring divider, one quotient bit of hue and saturation per stage
// stalls ripple back stage by stage, empty stages fill while the output waits
// reset clears only the stage valid bits, payload registers are not reset
`default_nettype none

`include "rgb_to_hsv_converter_assert.svh"

module rgb_to_hsv_converter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rhc_pkg::pixel_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rhc_pkg::hsv_t        out_data_o
);

  localparam int CB = rhc_pkg::CHANNEL_BITS;
  localparam int QB = rhc_pkg::QUO_BITS;
  localparam int HC = rhc_pkg::HUE_CALC_BITS;

  // stage 1: max, min, sector and channel difference
  logic                    s1_valid_q, s1_ready;
  logic [CB-1:0]           s1_max_d, s1_max_q, s1_delta_d, s1_delta_q;
  logic signed [CB:0]      s1_diff_d, s1_diff_q;
  rhc_pkg::sector_e        s1_sector_d, s1_sector_q;
  logic [CB-1:0]           min_val;

  always_comb begin
    if (in_data_i.red >= in_data_i.green && in_data_i.red >= in_data_i.blue) begin
      s1_sector_d = rhc_pkg::SECT_RED;
      s1_max_d    = in_data_i.red;
      s1_diff_d   = $signed({1'b0, in_data_i.green}) - $signed({1'b0, in_data_i.blue});
    end else if (in_data_i.green >= in_data_i.blue) begin
      s1_sector_d = rhc_pkg::SECT_GREEN;
      s1_max_d    = in_data_i.green;
      s1_diff_d   = $signed({1'b0, in_data_i.blue}) - $signed({1'b0, in_data_i.red});
    end else begin
      s1_sector_d = rhc_pkg::SECT_BLUE;
      s1_max_d    = in_data_i.blue;
      s1_diff_d   = $signed({1'b0, in_data_i.red}) - $signed({1'b0, in_data_i.green});
    end
    min_val = in_data_i.red;
    if (in_data_i.green < min_val) begin
      min_val = in_data_i.green;
    end
    if (in_data_i.blue < min_val) begin
      min_val = in_data_i.blue;
    end
    s1_delta_d = s1_max_d - min_val;
  end

  // stage 2: dividends and divisors
  logic                    s2_valid_q, s2_ready;
  rhc_pkg::div_data_t      s2_data_d, s2_data_q;
  logic signed [CB:0]      abs_diff_ext;

  always_comb begin
    abs_diff_ext        = s1_diff_q[CB] ? -s1_diff_q : s1_diff_q;
    s2_data_d.hue_rem   = rhc_pkg::REM_BITS'(rhc_pkg::HUE_UNIT)
                        * rhc_pkg::REM_BITS'(abs_diff_ext[CB-1:0]);
    s2_data_d.sat_rem   = rhc_pkg::REM_BITS'(rhc_pkg::CH_MAX)
                        * rhc_pkg::REM_BITS'(s1_delta_q);
    s2_data_d.hue_quo   = '0;
    s2_data_d.sat_quo   = '0;
    s2_data_d.delta     = s1_delta_q;
    s2_data_d.max_val   = s1_max_q;
    s2_data_d.neg       = s1_diff_q[CB];
    s2_data_d.grey      = (s1_delta_q == '0);
    s2_data_d.sector    = s1_sector_q;
  end

  // divider pipeline, index 0 is the stage 2 register
  logic               div_valid [QB+1];
  logic               div_ready [QB+1];
  rhc_pkg::div_data_t div_data  [QB+1];

  assign div_valid[0] = s2_valid_q;
  assign div_data[0]  = s2_data_q;

  for (genvar k = 0; k < QB; k++) begin : g_div
    rhc_div_stage #(
      .STEP_BIT(QB - 1 - k)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (div_valid[k]),
      .in_ready_o (div_ready[k]),
      .in_data_i  (div_data[k]),
      .out_valid_o(div_valid[k+1]),
      .out_ready_i(div_ready[k+1]),
      .out_data_o (div_data[k+1])
    );
  end

  // output stage: sign, sector offset and wrap
  logic               out_valid_q;
  rhc_pkg::hsv_t      out_data_d, out_data_q;
  rhc_pkg::div_data_t last;
  logic signed [HC-1:0] quo_s, offset_s, hue_s;

  assign last = div_data[QB];

  always_comb begin
    case (last.sector)
      rhc_pkg::SECT_RED:   offset_s = '0;
      rhc_pkg::SECT_GREEN: offset_s = HC'(2 * rhc_pkg::HUE_UNIT);
      rhc_pkg::SECT_BLUE:  offset_s = HC'(4 * rhc_pkg::HUE_UNIT);
      default:             offset_s = '0;
    endcase
    quo_s = HC'(last.hue_quo);
    hue_s = (last.neg ? -quo_s : quo_s) + offset_s;
    if (hue_s < 0) begin
      hue_s = hue_s + HC'(rhc_pkg::HUE_CIRCLE);
    end
    out_data_d.value = last.max_val;
    if (last.grey) begin
      out_data_d.hue        = '0;
      out_data_d.saturation = '0;
    end else begin
      out_data_d.hue        = hue_s[rhc_pkg::HUE_BITS-1:0];
      out_data_d.saturation = last.sat_quo[CB-1:0];
    end
  end

  // ready chain, each stage takes data when empty or when its successor moves
  assign div_ready[QB] = !out_valid_q || out_ready_i;
  assign s2_ready      = !s2_valid_q || div_ready[0];
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign in_ready_o    = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (div_ready[QB]) begin
        out_valid_q <= div_valid[QB];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_max_q    <= s1_max_d;
      s1_delta_q  <= s1_delta_d;
      s1_diff_q   <= s1_diff_d;
      s1_sector_q <= s1_sector_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_data_q <= s2_data_d;
    end
    if (div_valid[QB] && div_ready[QB]) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // zero saturation only comes from a grey pixel, which has zero hue
  `RHC_ASSERT_IMPL(a_grey_hue, clk_i, rst_ni,
    out_valid_o && out_data_o.saturation == '0, out_data_o.hue == '0)
  // wrapped hue stays inside one circle
  `RHC_ASSERT_IMPL(a_hue_range, clk_i, rst_ni,
    out_valid_o, 32'(out_data_o.hue) < 32'(rhc_pkg::HUE_CIRCLE))
  // hue quotient never exceeds one sector since the difference is bounded by delta
  `RHC_ASSERT_IMPL(a_quo_bound, clk_i, rst_ni,
    div_valid[QB] && !last.grey, 32'(last.hue_quo) <= 32'(rhc_pkg::HUE_UNIT))
  // a transaction leaving the divider lands in the output register
  `RHC_ASSERT_NEXT(a_out_load, clk_i, rst_ni,
    div_valid[QB] && div_ready[QB], out_valid_o)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// rgb to hsv converter testbench
// feeds pixels through the valid/ready input, predicts hue, saturation and
// value for each accepted pixel and checks every output transaction in order,
// with random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  rhc_pkg::pixel_t in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  rhc_pkg::hsv_t   out_data;

  rhc_pkg::hsv_t expected_hsv[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            stall_left = 0;
  bit            quiet = 1'b0;

  rgb_to_hsv_converter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk_i = ~clk_i;

  function automatic rhc_pkg::hsv_t predict_hsv(rhc_pkg::pixel_t p);
    int               r, g, b, mx, mn, dl, df, off, h;
    rhc_pkg::sector_e sect;
    rhc_pkg::hsv_t    res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    res.value = mx[rhc_pkg::CHANNEL_BITS-1:0];
    if (dl == 0) begin
      res.hue = '0;
      res.saturation = '0;
      return res;
    end
    res.saturation = rhc_pkg::CHANNEL_BITS'((rhc_pkg::CH_MAX * dl) / mx);
    // ties go to red, then green
    if (r == mx) sect = rhc_pkg::SECT_RED;
    else if (g == mx) sect = rhc_pkg::SECT_GREEN;
    else sect = rhc_pkg::SECT_BLUE;
    case (sect)
      rhc_pkg::SECT_RED: begin
        df = g - b;
        off = 0;
      end
      rhc_pkg::SECT_GREEN: begin
        df = b - r;
        off = 2 * rhc_pkg::HUE_UNIT;
      end
      default: begin
        df = r - g;
        off = 4 * rhc_pkg::HUE_UNIT;
      end
    endcase
    // signed int division truncates toward zero
    h = (rhc_pkg::HUE_UNIT * df) / dl + off;
    if (h < 0) h = h + rhc_pkg::HUE_CIRCLE;
    res.hue = rhc_pkg::HUE_BITS'(h);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // output side stalls, most short and a few long
  always @(posedge clk_i) begin
    if (quiet || stall_left == 0) begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 20) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      end
    end else begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    rhc_pkg::hsv_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) expected_hsv.push_back(predict_hsv(in_data));
      if (out_valid && out_ready) begin
        if (expected_hsv.size() == 0) begin
          $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                   out_data.hue, out_data.saturation, out_data.value);
          error_count++;
        end else begin
          want = expected_hsv.pop_front();
          if (out_data.hue !== want.hue) begin
            $display("%0t: hue mismatch expected %0d actual %0d", $time,
                     want.hue, out_data.hue);
            error_count++;
          end
          if (out_data.saturation !== want.saturation) begin
            $display("%0t: saturation mismatch expected %0d actual %0d", $time,
                     want.saturation, out_data.saturation);
            error_count++;
          end
          if (out_data.value !== want.value) begin
            $display("%0t: value mismatch expected %0d actual %0d", $time,
                     want.value, out_data.value);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a rising edge, returns at the edge where the pixel is taken
  task automatic send_pixel(input rhc_pkg::pixel_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) begin
        in_data <= rhc_pkg::pixel_t'($urandom);
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    rhc_pkg::pixel_t p;
    p.red = r[rhc_pkg::CHANNEL_BITS-1:0];
    p.green = g[rhc_pkg::CHANNEL_BITS-1:0];
    p.blue = b[rhc_pkg::CHANNEL_BITS-1:0];
    send_pixel(p);
  endtask

  task automatic test_directed();
    // grey: black, white, mid
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    // primaries and secondaries
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    // negative hue wraps around the circle
    send_rgb(255, 0, 1);
    send_rgb(200, 10, 190);
    // smallest delta and smallest max
    send_rgb(1, 0, 0);
    send_rgb(0, 1, 0);
    send_rgb(0, 0, 1);
    send_rgb(255, 254, 254);
    send_rgb(254, 255, 254);
    send_rgb(254, 254, 255);
    send_rgb(255, 254, 255);
    // red and blue sectors with both diff signs, green with a negative diff
    send_rgb(255, 128, 0);
    send_rgb(128, 255, 0);
    send_rgb(0, 128, 255);
    send_rgb(128, 0, 255);
    send_rgb(170, 85, 170);
    send_rgb(1, 2, 3);
  endtask

  function automatic rhc_pkg::pixel_t random_pixel();
    rhc_pkg::pixel_t p;
    int              kind, v, d;
    p = rhc_pkg::pixel_t'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // grey
      v = $urandom_range(0, 255);
      p.red = v[7:0];
      p.green = v[7:0];
      p.blue = v[7:0];
    end else if (kind < 25) begin
      // two channels tied
      case ($urandom_range(0, 2))
        0: p.green = p.red;
        1: p.blue = p.green;
        default: p.blue = p.red;
      endcase
    end else if (kind < 40) begin
      // near grey, small delta
      v = $urandom_range(0, 255);
      d = $urandom_range(0, 3);
      p.red = 8'(v);
      p.green = 8'((v + d > 255) ? v - d : v + d);
      p.blue = 8'((v >= d) ? v - $urandom_range(0, d) : v);
    end else if (kind < 50) begin
      // channels pinned at the extremes
      if ($urandom_range(0, 1)) p.red = {8{p.red[0]}};
      if ($urandom_range(0, 1)) p.green = {8{p.green[0]}};
      if ($urandom_range(0, 1)) p.blue = {8{p.blue[0]}};
    end else if (kind < 60) begin
      // dark pixels
      p.red = 8'($urandom_range(0, 7));
      p.green = 8'($urandom_range(0, 7));
      p.blue = 8'($urandom_range(0, 7));
    end
    return p;
  endfunction

  task automatic test_random(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_back_to_back(input int count);
    quiet = 1'b1;
    repeat (count) send_pixel(random_pixel());
    quiet = 1'b0;
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    // let the checker record the last input transaction first
    @(posedge clk_i);
    while (expected_hsv.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    test_back_to_back(150);
    test_random(450);
    finish_run();
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_div_stage.sv
sv/rgb_to_hsv_converter.sv
tb/tb.sv
